[rtl/pcswl_pkg.sv]
// Shared types, sizes and helpers for the per-client sliding window limiter.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
package pcswl_pkg;

  localparam int NUM_CLIENTS = 16;
  localparam int MAX_SLOTS   = 8;
  localparam int TIME_BITS   = 32;

  localparam int ENT_W     = (NUM_CLIENTS > 1) ? $clog2(NUM_CLIENTS) : 1;
  localparam int SLOT_W    = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int CNT_W     = $clog2(MAX_SLOTS + 1);
  localparam int MEM_DEPTH = NUM_CLIENTS * MAX_SLOTS;
  localparam int MEM_AW    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

  // configuration register indexes
  localparam logic [1:0] REG_QUERY_LIMIT = 2'd0;
  localparam logic [1:0] REG_WINDOW      = 2'd1;

  localparam logic [3:0]  MAXQ_RESET   = 4'd5;
  localparam logic [15:0] WINDOW_RESET = 16'd10;

  typedef logic [TIME_BITS-1:0] stamp_t;

  typedef enum logic [1:0] {
    VERDICT_ADMIT = 2'd0,
    VERDICT_LIMIT = 2'd1,
    VERDICT_FULL  = 2'd2
  } verdict_t;

  typedef struct packed {
    logic [31:0] client_addr;
    logic [31:0] now_seconds;
  } query_t;

  typedef struct packed {
    verdict_t   verdict;
    logic [3:0] recent_count;
  } result_t;

  // age modulo 2^TIME_BITS, strictly greater than the window
  function automatic logic stamp_expired(stamp_t stamp, stamp_t now, logic [15:0] win);
    stamp_t      age;
    logic [63:0] age_w;
    logic [63:0] win_w;
    age   = now - stamp;
    age_w = 64'(age);
    win_w = 64'(win);
    return age_w > win_w;
  endfunction

  // (head + k) mod MAX_SLOTS, with head and k both below MAX_SLOTS
  function automatic logic [SLOT_W-1:0] wrap_slot(logic [SLOT_W-1:0] head,
                                                  logic [CNT_W-1:0] k);
    logic [CNT_W:0] s;
    s = (CNT_W + 1)'(head) + (CNT_W + 1)'(k);
    if (s >= (CNT_W + 1)'(MAX_SLOTS)) begin
      s = s - (CNT_W + 1)'(MAX_SLOTS);
    end
    return SLOT_W'(s);
  endfunction

endpackage

[rtl/pcswl_front.sv]
// Front queue: takes query transfers from the input side and holds them
// for the lookup engine. Depends on pcswl_pkg.
`timescale 1ns / 1ps
module pcswl_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  output logic                  full,
  input  logic [31:0]           in_client_addr,
  input  logic [31:0]           in_now_seconds,
  output logic                  q_valid,
  output pcswl_pkg::query_t     q_item,
  input  logic                  q_pop
);
  import pcswl_pkg::*;

  query_t     slot_r [2];
  logic       wptr_r;
  logic       rptr_r;
  logic [1:0] cnt_r;
  logic       do_wr;
  logic       do_rd;

  assign full    = (cnt_r == 2'd2);
  assign q_valid = (cnt_r != 2'd0);
  assign q_item  = slot_r[rptr_r];
  assign do_wr   = push && !full;
  assign do_rd   = q_pop && q_valid;

  // store incoming query
  always_ff @(posedge clk) begin
    if (do_wr) begin
      slot_r[wptr_r] <= '{client_addr: in_client_addr, now_seconds: in_now_seconds};
    end
  end

  // advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (do_wr) wptr_r <= !wptr_r;
      if (do_rd) rptr_r <= !rptr_r;
      cnt_r <= cnt_r + {1'b0, do_wr} - {1'b0, do_rd};
    end
  end

endmodule

[rtl/pcswl_outq.sv]
// Result queue: holds verdicts until the output side takes them.
// Depends on pcswl_pkg.
`timescale 1ns / 1ps
module pcswl_outq (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  res_push,
  input  pcswl_pkg::result_t    res_item,
  output logic                  res_full,
  output logic                  empty,
  input  logic                  pop,
  output logic [1:0]            out_verdict,
  output logic [3:0]            out_recent_count
);
  import pcswl_pkg::*;

  result_t    slot_r [2];
  logic       wptr_r;
  logic       rptr_r;
  logic [1:0] cnt_r;
  logic       do_wr;
  logic       do_rd;

  assign res_full         = (cnt_r == 2'd2);
  assign empty            = (cnt_r == 2'd0);
  assign out_verdict      = slot_r[rptr_r].verdict;
  assign out_recent_count = slot_r[rptr_r].recent_count;
  assign do_wr            = res_push && !res_full;
  assign do_rd            = pop && !empty;

  // store result
  always_ff @(posedge clk) begin
    if (do_wr) begin
      slot_r[wptr_r] <= res_item;
    end
  end

  // advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (do_wr) wptr_r <= !wptr_r;
      if (do_rd) rptr_r <= !rptr_r;
      cnt_r <= cnt_r + {1'b0, do_wr} - {1'b0, do_rd};
    end
  end

endmodule

[rtl/pcswl_core.sv]
// Lookup engine: client table, stamp ring memory, pruning and verdicts,
// plus the configuration registers. Depends on pcswl_pkg.
`timescale 1ns / 1ps
module pcswl_core (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  input  logic [1:0]            cfg_index,
  input  logic [15:0]           cfg_data,
  input  logic                  q_valid,
  input  pcswl_pkg::query_t     q_item,
  output logic                  q_pop,
  output logic                  res_push,
  output pcswl_pkg::result_t    res_item,
  input  logic                  res_full
);
  import pcswl_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_FREE   = 6'b000010,
    S_FCHK   = 6'b000100,
    S_PRUNE  = 6'b001000,
    S_PCHK   = 6'b010000,
    S_DECIDE = 6'b100000
  } state_t;

  state_t             state_r;
  logic [31:0]        addr_in_r;
  stamp_t             now_r;
  logic [ENT_W-1:0]   ent_r;
  logic [CNT_W-1:0]   k_r;
  logic [3:0]         maxq_r;
  logic [15:0]        win_r;

  logic               valid_r [NUM_CLIENTS];
  logic [31:0]        eaddr_r [NUM_CLIENTS];
  logic [SLOT_W-1:0]  head_r  [NUM_CLIENTS];
  logic [CNT_W-1:0]   count_r [NUM_CLIENTS];

  stamp_t             mem [MEM_DEPTH];
  stamp_t             rdata_r;

  logic               hit;
  logic [ENT_W-1:0]   hit_idx;
  logic               cur_valid;
  logic [SLOT_W-1:0]  cur_head;
  logic [CNT_W-1:0]   cur_count;
  logic               expired;
  int                 limit;
  logic               admit;
  logic               rd_en;
  logic [SLOT_W-1:0]  rd_slot;
  logic [MEM_AW-1:0]  rd_addr;
  logic               wr_en;
  logic [MEM_AW-1:0]  wr_addr;
  logic               take;
  logic               last_ent;
  logic [CNT_W:0]     cnt_inc;

  assign cur_valid = valid_r[ent_r];
  assign cur_head  = head_r[ent_r];
  assign cur_count = count_r[ent_r];
  assign expired   = stamp_expired(rdata_r, now_r, win_r);
  assign limit     = (int'(maxq_r) > MAX_SLOTS) ? MAX_SLOTS : int'(maxq_r);
  assign admit     = int'(cur_count) < limit;
  assign take      = !cur_valid || (k_r == cur_count);
  assign last_ent  = (ent_r == ENT_W'(NUM_CLIENTS - 1));
  assign cnt_inc   = (CNT_W + 1)'(cur_count) + (CNT_W + 1)'(1);
  assign q_pop     = (state_r == S_IDLE) && q_valid && !res_full;

  // search the table for the client address, lowest index first
  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int e = NUM_CLIENTS - 1; e >= 0; e--) begin
      if (valid_r[e] && eaddr_r[e] == q_item.client_addr) begin
        hit     = 1'b1;
        hit_idx = ENT_W'(e);
      end
    end
  end

  // stamp memory port control
  always_comb begin
    rd_en   = 1'b0;
    rd_slot = cur_head;
    if (state_r == S_FREE && !take) begin
      rd_en   = 1'b1;
      rd_slot = wrap_slot(cur_head, k_r);
    end else if (state_r == S_PRUNE && cur_count != '0) begin
      rd_en = 1'b1;
    end
    rd_addr = MEM_AW'(int'(ent_r) * MAX_SLOTS + int'(rd_slot));
    wr_en   = (state_r == S_DECIDE) && admit;
    wr_addr = MEM_AW'(int'(ent_r) * MAX_SLOTS + int'(wrap_slot(cur_head, cur_count)));
  end

  // result transfer to the output queue
  always_comb begin
    res_push = 1'b0;
    res_item = '{verdict: VERDICT_ADMIT, recent_count: 4'd0};
    if (state_r == S_DECIDE) begin
      res_push = 1'b1;
      if (admit) begin
        res_item.recent_count = 4'(cnt_inc);
      end else begin
        res_item.verdict      = VERDICT_LIMIT;
        res_item.recent_count = 4'(cur_count);
      end
    end else if (state_r == S_FCHK && !expired && last_ent) begin
      res_push         = 1'b1;
      res_item.verdict = VERDICT_FULL;
    end
  end

  // stamp memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= now_r;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      maxq_r <= MAXQ_RESET;
      win_r  <= WINDOW_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == REG_QUERY_LIMIT) maxq_r <= cfg_data[3:0];
      if (cfg_index == REG_WINDOW)      win_r  <= cfg_data;
    end
  end

  // hold the query under work
  always_ff @(posedge clk) begin
    if (q_pop) begin
      addr_in_r <= q_item.client_addr;
      now_r     <= stamp_t'(q_item.now_seconds);
    end
  end

  // entry addresses
  always_ff @(posedge clk) begin
    if (state_r == S_FREE && take) begin
      eaddr_r[ent_r] <= addr_in_r;
    end
  end

  // sequencer and ring bookkeeping
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ent_r   <= '0;
      k_r     <= '0;
      for (int e = 0; e < NUM_CLIENTS; e++) begin
        valid_r[e] <= 1'b0;
        head_r[e]  <= '0;
        count_r[e] <= '0;
      end
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (q_pop) begin
            k_r <= '0;
            if (hit) begin
              ent_r   <= hit_idx;
              state_r <= S_PRUNE;
            end else begin
              ent_r   <= '0;
              state_r <= S_FREE;
            end
          end
        end
        S_FREE: begin
          if (take) begin
            valid_r[ent_r] <= 1'b1;
            head_r[ent_r]  <= '0;
            count_r[ent_r] <= '0;
            state_r        <= S_PRUNE;
          end else begin
            state_r <= S_FCHK;
          end
        end
        S_FCHK: begin
          if (expired) begin
            k_r     <= k_r + CNT_W'(1);
            state_r <= S_FREE;
          end else if (last_ent) begin
            state_r <= S_IDLE;
          end else begin
            ent_r   <= ent_r + ENT_W'(1);
            k_r     <= '0;
            state_r <= S_FREE;
          end
        end
        S_PRUNE: begin
          state_r <= (cur_count != '0) ? S_PCHK : S_DECIDE;
        end
        S_PCHK: begin
          if (expired) begin
            head_r[ent_r]  <= wrap_slot(cur_head, CNT_W'(1));
            count_r[ent_r] <= cur_count - CNT_W'(1);
            state_r        <= S_PRUNE;
          end else begin
            state_r <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (admit) begin
            count_r[ent_r] <= CNT_W'(cnt_inc);
          end
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

[rtl/per_client_sliding_window_limiter.sv]
// Query flow: a known client is pruned of expired stamps from its oldest end, then
// decided; a new client first walks the table for a free or fully expired entry,
// and a full table gives its result from that walk. Result readable the cycle after.
// Throughput: one query at a time; the next is taken once the engine is back in
// idle and the output queue has room.
// Reset: rst_n synchronous, active low; clears queues and table, loads limit 5, window 10.
`timescale 1ns / 1ps
module per_client_sliding_window_limiter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [31:0] in_client_addr,
  input  logic [31:0] in_now_seconds,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  out_verdict,
  output logic [3:0]  out_recent_count,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import pcswl_pkg::*;

  logic    q_valid;
  query_t  q_item;
  logic    q_pop;
  logic    res_push;
  result_t res_item;
  logic    res_full;

  // configuration is always taken
  assign cfg_ready = 1'b1;

  pcswl_front u_front (
    .clk, .rst_n, .push, .full, .in_client_addr, .in_now_seconds,
    .q_valid, .q_item, .q_pop
  );

  pcswl_core u_core (
    .clk, .rst_n, .cfg_valid, .cfg_index, .cfg_data,
    .q_valid, .q_item, .q_pop, .res_push, .res_item, .res_full
  );

  pcswl_outq u_outq (
    .clk, .rst_n, .res_push, .res_item, .res_full, .empty, .pop,
    .out_verdict, .out_recent_count
  );

  // a result never meets a full output queue
  assert property (@(posedge clk) disable iff (!rst_n) res_push |-> !res_full)
    else $error("result pushed into full output queue");

  // a query is only started with room for its result
  assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> (q_valid && !res_full))
    else $error("query started without result space");

  // a refused table-full query reports no stamps
  assert property (@(posedge clk) disable iff (!rst_n)
      (res_push && res_item.verdict == VERDICT_FULL) |-> res_item.recent_count == 4'd0)
    else $error("table full result with nonzero count");

  // an admitted query always holds at least its own stamp
  assert property (@(posedge clk) disable iff (!rst_n)
      (res_push && res_item.verdict == VERDICT_ADMIT) |-> res_item.recent_count != 4'd0)
    else $error("admitted result with zero count");

endmodule

[sim/per_client_sliding_window_limiter_tb.sv]
// Self-checking testbench for the per-client sliding window limiter.
// Depends on pcswl_pkg and per_client_sliding_window_limiter; it predicts
// each verdict and recent count from its own client table and stamp rings.
`timescale 1ns / 1ps
module per_client_sliding_window_limiter_tb;
  import pcswl_pkg::*;

  localparam int STALL_LIMIT = 5000;
  localparam int DUE_DEPTH   = 16;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [31:0] in_client_addr = '0;
  logic [31:0] in_now_seconds = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [1:0]  out_verdict;
  logic [3:0]  out_recent_count;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  per_client_sliding_window_limiter u_dut (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full),
    .in_client_addr(in_client_addr), .in_now_seconds(in_now_seconds),
    .empty(empty), .pop(pop), .out_verdict(out_verdict),
    .out_recent_count(out_recent_count), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  // shadow of the client table and settings
  logic [3:0]  lim_max_q;
  logic [15:0] lim_window;
  logic        tbl_valid [NUM_CLIENTS];
  logic [31:0] tbl_addr  [NUM_CLIENTS];
  stamp_t      tbl_stamp [NUM_CLIENTS*MAX_SLOTS];
  int          tbl_head  [NUM_CLIENTS];
  int          tbl_count [NUM_CLIENTS];

  // predicted results in order, as a ring with running write and read counts
  result_t     due_buf [DUE_DEPTH];
  int          due_wr = 0;
  int          due_rd = 0;
  int          mismatches = 0;
  int          queries_sent = 0;
  int          verdicts_seen = 0;
  int          n_admit = 0, n_limit = 0, n_full = 0;
  int          idle_cycles = 0;
  logic [31:0] clock_now;
  logic [31:0] client_pool[20];

  function automatic logic is_stale(stamp_t stamp, stamp_t now);
    stamp_t age;
    age = now - stamp;
    return age > {16'd0, lim_window};
  endfunction

  // work out the verdict for one query and update the shadow table
  function automatic result_t rate_verdict(logic [31:0] a, stamp_t now);
    result_t r;
    int      hit;
    int      lim;
    bit      stale_all;
    hit = -1;
    for (int e = 0; e < NUM_CLIENTS; e++)
      if (hit < 0 && tbl_valid[e] && tbl_addr[e] == a) hit = e;
    if (hit < 0) begin
      for (int e = 0; e < NUM_CLIENTS; e++) begin
        if (hit < 0) begin
          stale_all = 1;
          for (int k = 0; k < tbl_count[e]; k++)
            if (!is_stale(tbl_stamp[e*MAX_SLOTS + (tbl_head[e]+k)%MAX_SLOTS], now))
              stale_all = 0;
          if (!tbl_valid[e] || stale_all) hit = e;
        end
      end
      if (hit < 0) begin
        r.verdict = VERDICT_FULL;
        r.recent_count = 4'd0;
        return r;
      end
      tbl_valid[hit] = 1'b1;
      tbl_addr[hit]  = a;
      tbl_head[hit]  = 0;
      tbl_count[hit] = 0;
    end
    // drop expired stamps from the oldest end only
    while (tbl_count[hit] > 0 && is_stale(tbl_stamp[hit*MAX_SLOTS + tbl_head[hit]], now)) begin
      tbl_head[hit] = (tbl_head[hit] + 1) % MAX_SLOTS;
      tbl_count[hit]--;
    end
    lim = (lim_max_q > MAX_SLOTS) ? MAX_SLOTS : int'(lim_max_q);
    if (tbl_count[hit] >= lim) begin
      r.verdict = VERDICT_LIMIT;
    end else begin
      tbl_stamp[hit*MAX_SLOTS + (tbl_head[hit]+tbl_count[hit])%MAX_SLOTS] = now;
      tbl_count[hit]++;
      r.verdict = VERDICT_ADMIT;
    end
    r.recent_count = 4'(tbl_count[hit]);
    return r;
  endfunction

  task automatic report_mismatch(string what);
    mismatches++;
    $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  // present one query and hold it until the transfer; push stays high
  task automatic send_query(logic [31:0] a, logic [31:0] now);
    push <= 1'b1;
    in_client_addr <= a;
    in_now_seconds <= now;
    do @(posedge clk); while (full);
    due_buf[due_wr % DUE_DEPTH] = rate_verdict(a, now);
    due_wr++;
    queries_sent++;
  endtask

  task automatic idle_sender(int cycles);
    push <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    @(posedge clk);
    while (due_wr != due_rd) @(posedge clk);
  endtask

  // register write, only with the block idle
  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    wait_drained();
    repeat (8) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_QUERY_LIMIT) lim_max_q = val[3:0];
    else if (idx == REG_WINDOW) lim_window = val;
  endtask

  // check each popped verdict against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && pop && !empty) begin
      verdicts_seen++;
      if (due_wr == due_rd) begin
        report_mismatch("verdict with no query outstanding");
      end else begin
        result_t exp_r;
        exp_r = due_buf[due_rd % DUE_DEPTH];
        due_rd++;
        if (out_verdict != exp_r.verdict)
          report_mismatch($sformatf("verdict %0d, predicted %0d", out_verdict, exp_r.verdict));
        if (out_recent_count != exp_r.recent_count)
          report_mismatch($sformatf("recent_count %0d, predicted %0d",
                                    out_recent_count, exp_r.recent_count));
        case (exp_r.verdict)
          VERDICT_ADMIT: n_admit++;
          VERDICT_LIMIT: n_limit++;
          default:       n_full++;
        endcase
      end
    end
  end

  // receiver stalls: free-running spells, then random holds of varying length
  int stall_left = 0;
  int stall_phase = 0;
  always @(posedge clk) begin
    stall_phase <= (stall_phase + 1) % 300;
    if (stall_left > 0) begin
      pop <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (stall_phase < 100) begin
      pop <= 1'b1;
    end else if ($urandom_range(0, 3) == 0) begin
      pop <= 1'b0;
      stall_left <= (stall_phase < 200) ? $urandom_range(0, 3) : $urandom_range(5, 25);
    end else begin
      pop <= 1'b1;
    end
  end

  // watchdog: end the run if nothing transfers for too long
  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready) || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
      $display("FAIL");
      $finish;
    end
  end

  // defaults: limit reached, expiry at the window edge, time wrap, time stepping back
  task automatic test_directed();
    logic [31:0] t;
    t = $urandom;
    send_query(32'h0000_0000, t);
    send_query(32'h0000_0000, t);
    send_query(32'h0000_0000, t + 1);
    send_query(32'h0000_0000, t + 2);
    send_query(32'h0000_0000, t + 3);
    send_query(32'h0000_0000, t + 3);
    send_query(32'hFFFF_FFFF, t + 3);
    send_query(32'h0000_0000, t + 11);
    send_query(32'h0000_0000, t + 12);
    send_query(32'h0000_0000, t + 5);
    send_query(32'h1234_5678, t - 20);
    send_query(32'hFFFF_FFFF, t + 14);
    idle_sender(3);
    send_query(32'hA5A5_5A5A, 32'hFFFF_FFFE);
    send_query(32'hA5A5_5A5A, 32'hFFFF_FFFF);
    send_query(32'hA5A5_5A5A, 32'h0000_0000);
    send_query(32'hA5A5_5A5A, 32'h0000_0009);
    send_query(32'hA5A5_5A5A, 32'h0000_000C);
    idle_sender(2);
  endtask

  // limit of zero, limit above the ring size, zero and widest windows
  task automatic test_reg_extremes();
    logic [31:0] t;
    t = $urandom;
    write_reg(REG_QUERY_LIMIT, 16'd0);
    send_query(32'h5555_AAAA, t);
    send_query(32'h5555_AAAA, t + 1);
    write_reg(REG_QUERY_LIMIT, 16'hFFFF);
    write_reg(REG_WINDOW, 16'd0);
    send_query(32'h0F0F_0F0F, t + 2);
    send_query(32'h0F0F_0F0F, t + 2);
    send_query(32'h0F0F_0F0F, t + 3);
    write_reg(REG_WINDOW, 16'hFFFF);
    repeat (10) send_query(32'hF0F0_F0F0, t + 4);
    send_query(32'hF0F0_F0F0, t + 65539);
    send_query(32'hF0F0_F0F0, t + 65540);
    idle_sender(1);
  endtask

  // random bursts over a small client pool so the table fills and recycles
  task automatic test_random_phase(logic [3:0] mq, logic [15:0] win, int count,
                                   int max_step, logic [31:0] t0);
    int burst;
    int sent;
    logic [31:0] a;
    write_reg(REG_QUERY_LIMIT, {12'd0, mq});
    write_reg(REG_WINDOW, win);
    foreach (client_pool[i]) client_pool[i] = $urandom;
    clock_now = t0;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 12);
      repeat (burst) begin
        if ($urandom_range(0, 15) == 0) a = $urandom;
        else a = client_pool[$urandom_range(0, 19)];
        if ($urandom_range(0, 30) == 0) clock_now += win + $urandom_range(1, 3);
        else clock_now += $urandom_range(0, max_step);
        send_query(a, clock_now);
        sent++;
      end
      if ($urandom_range(0, 2) != 0) idle_sender($urandom_range(1, 8));
      if (sent >= count / 2 && sent - burst < count / 2) wait_drained();
    end
  endtask

  initial begin
    lim_max_q = MAXQ_RESET;
    lim_window = WINDOW_RESET;
    foreach (tbl_valid[i]) begin
      tbl_valid[i] = 1'b0;
      tbl_addr[i] = '0;
      tbl_head[i] = 0;
      tbl_count[i] = 0;
    end
    foreach (tbl_stamp[i]) tbl_stamp[i] = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_reg_extremes();
    test_random_phase(4'd5, 16'd10, 160, 2, $urandom);
    test_random_phase(4'd1, 16'd0, 100, 1, 32'hFFFF_FF80);
    test_random_phase(4'd8, 16'd3, 160, 1, $urandom);
    test_random_phase(4'd3, 16'd65535, 120, 40, $urandom);
    test_random_phase(4'd2, 16'd7, 160, 3, $urandom);

    wait_drained();
    repeat (300) @(posedge clk);
    $display("Covered %0d queries, %0d verdicts: %0d admitted, %0d limited, %0d table full,",
             queries_sent, verdicts_seen, n_admit, n_limit, n_full);
    $display("across limits 0..15 and windows 0..65535 with time wrap; %0d mismatches",
             mismatches);
    if (mismatches == 0 && due_wr == due_rd) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/pcswl_pkg.sv
rtl/pcswl_front.sv
rtl/pcswl_outq.sv
rtl/pcswl_core.sv
rtl/per_client_sliding_window_limiter.sv
sim/per_client_sliding_window_limiter_tb.sv
